@@ hw/rtl/particle_pool_update_defines.svh @@
// assertion helpers used by ppu_back
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH

// implication checked on every edge outside reset
`define PPU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define PPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/ppu_pkg.sv @@
package ppu_pkg;

	localparam int unsigned PoolDepthDefault = 32;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_TICK   = 3'd1,
		OP_ACCEL  = 3'd2,
		OP_MOVE   = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_LIST   = 3'd5
	} op_t;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StFull = 2'd1;
	localparam logic [1:0] StEmpty = 2'd2;

	// classified command handed from front to back
	typedef struct packed {
		logic [2:0]  op;
		logic [23:0] a_x;   // position or delta
		logic [23:0] a_y;
		logic [23:0] v_x;
		logic [23:0] v_y;
		logic [15:0] life;
		logic [31:0] tint;
		logic [15:0] elapsed;
	} cmd_t;

	function automatic logic [15:0] decay_entry(input logic [3:0] k);
		logic [15:0] r;
		begin
			case (k)
				4'd0: r = 16'd23170;
				4'd1: r = 16'd27554;
				4'd2: r = 16'd30048;
				4'd3: r = 16'd31379;
				4'd4: r = 16'd32066;
				4'd5: r = 16'd32415;
				4'd6: r = 16'd32591;
				4'd7: r = 16'd32679;
				4'd8: r = 16'd32724;
				4'd9: r = 16'd32746;
				4'd10: r = 16'd32757;
				4'd11: r = 16'd32762;
				default: r = 16'd32768;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		logic signed [23:0] r;
		begin
			if (v > 26'sd8388607) r = 24'sh7FFFFF;
			else if (v < -26'sd8388608) r = 24'sh800000;
			else r = v[23:0];
			return r;
		end
	endfunction

	function automatic logic frame_of(input logic [15:0] l);
		logic r;
		begin
			if (l >= 16'd2458) r = 1'b0;
			else if (l >= 16'd1229) r = 1'b1;
			else if (l >= 16'd615) r = 1'b0;
			else r = 1'b1;
			return r;
		end
	endfunction

endpackage

@@ hw/rtl/ppu_front.sv @@
module ppu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ppu_pkg::cmd_t   cmd_in,
	output logic            q_valid,
	output ppu_pkg::cmd_t   q_cmd,
	input  logic            q_pop,
	input  logic            back_busy
);

	// two-entry command queue; front takes a beat only when the queue is empty and the back is idle
	ppu_pkg::cmd_t mem_q [ppu_pkg::QueueDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	// one op in flight at a time: the pool state of the next op depends on this one
	assign busy = (cnt_q != 2'd0) || back_busy;
	assign push = start && !busy;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ hw/rtl/ppu_back.sv @@
`include "particle_pool_update_defines.svh"
module ppu_back #(
	parameter int unsigned POOL_DEPTH = ppu_pkg::PoolDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  ppu_pkg::cmd_t        q_cmd,
	output logic                 q_pop,
	output logic                 back_busy,
	output logic                 res_valid,
	output logic signed [23:0]   draw_x,
	output logic signed [23:0]   draw_y,
	output logic [31:0]          draw_color,
	output logic                 frame,
	output logic [1:0]           status,
	output logic [6:0]           live_count,
	output logic                 last
);

	localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DECAY, S_RD, S_WAIT, S_MUL, S_WR, S_DONE
	} state_t;

	// one wide word per particle: px py vx vy life color
	typedef struct packed {
		logic [23:0] px;
		logic [23:0] py;
		logic [23:0] vx;
		logic [23:0] vy;
		logic [15:0] life;
		logic [31:0] color;
	} part_t;

	part_t mem [POOL_DEPTH];
	part_t rd_q;

	state_t state_q;
	ppu_pkg::cmd_t cmd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ri_q, wi_q;
	logic [3:0] bit_q;
	logic [16:0] fac_q;
	logic [16:0] fac_nxt;
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	part_t mem_wd;

	// multiply stage registers
	logic signed [40:0] mpx_s1, mpy_s1;
	logic signed [41:0] mvx_s1, mvy_s1;
	part_t p_s1;
	logic keep_s1;

	logic signed [40:0] prx, pry;
	logic signed [41:0] pvx, pvy;
	logic signed [33:0] decay_prod;

	function automatic logic signed [23:0] sat31(input logic signed [30:0] v);
		if (v > 31'sd8388607) return 24'sh7FFFFF;
		if (v < -31'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	assign decay_prod = $signed({1'b0, fac_q}) * $signed({1'b0, ppu_pkg::decay_entry(bit_q)});
	assign fac_nxt = cmd_q.elapsed[4'd11 - bit_q] ?
		17'((decay_prod + 34'sd16384) >>> 15) : fac_q;
	assign prx = $signed(rd_q.vx) * $signed({1'b0, cmd_q.elapsed});
	assign pry = $signed(rd_q.vy) * $signed({1'b0, cmd_q.elapsed});
	assign pvx = $signed(rd_q.vx) * $signed({1'b0, fac_q});
	assign pvy = $signed(rd_q.vy) * $signed({1'b0, fac_q});

	assign mem_ra = ri_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	logic signed [41:0] t12x, t12y;
	logic signed [42:0] t15x, t15y;
	logic signed [30:0] ax, ay;
	part_t upd;
	always_comb begin
		t12x = mpx_s1 + 41'sd2048;
		t12y = mpy_s1 + 41'sd2048;
		t15x = mvx_s1 + 42'sd16384;
		t15y = mvy_s1 + 42'sd16384;
		upd = p_s1;
		ax = 31'($signed(p_s1.px)) + 31'($signed(t12x[41:12]));
		ay = 31'($signed(p_s1.py)) + 31'($signed(t12y[41:12]));
		upd.px = sat31(ax);
		upd.py = sat31(ay);
		upd.vx = ppu_pkg::sat24(26'($signed(t15x[42:15])));
		upd.vy = ppu_pkg::sat24(26'($signed(t15y[42:15])));
		upd.life = p_s1.life - cmd_q.elapsed;
	end

	part_t newp, addp;
	always_comb begin
		newp.px = cmd_q.a_x;
		newp.py = cmd_q.a_y;
		newp.vx = cmd_q.v_x;
		newp.vy = cmd_q.v_y;
		newp.life = cmd_q.life;
		newp.color = cmd_q.tint;
		addp = rd_q;
		if (cmd_q.op == ppu_pkg::OP_ACCEL) begin
			addp.vx = ppu_pkg::sat24(26'($signed(rd_q.vx)) + 26'($signed(cmd_q.a_x)));
			addp.vy = ppu_pkg::sat24(26'($signed(rd_q.vy)) + 26'($signed(cmd_q.a_y)));
		end else begin
			addp.px = ppu_pkg::sat24(26'($signed(rd_q.px)) + 26'($signed(cmd_q.a_x)));
			addp.py = ppu_pkg::sat24(26'($signed(rd_q.py)) + 26'($signed(cmd_q.a_y)));
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wi_q[AW-1:0];
		mem_wd = newp;
		if (state_q == S_IDLE && q_valid && q_cmd.op == ppu_pkg::OP_CREATE &&
				count_q < CW'(POOL_DEPTH)) begin
			mem_we = 1'b1;
			mem_wa = count_q[AW-1:0];
			mem_wd.px = q_cmd.a_x;
			mem_wd.py = q_cmd.a_y;
			mem_wd.vx = q_cmd.v_x;
			mem_wd.vy = q_cmd.v_y;
			mem_wd.life = q_cmd.life;
			mem_wd.color = q_cmd.tint;
		end else if (state_q == S_WR && cmd_q.op == ppu_pkg::OP_TICK && keep_s1) begin
			mem_we = 1'b1;
			mem_wd = upd;
		end else if (state_q == S_MUL && (cmd_q.op == ppu_pkg::OP_ACCEL ||
				cmd_q.op == ppu_pkg::OP_MOVE)) begin
			mem_we = 1'b1;
			mem_wa = ri_q[AW-1:0];
			mem_wd = addp;
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign back_busy = state_q != S_IDLE;

	always_ff @(posedge clk) begin
		mpx_s1 <= prx;
		mpy_s1 <= pry;
		mvx_s1 <= 42'(pvx);
		mvy_s1 <= 42'(pvy);
		p_s1 <= rd_q;
		keep_s1 <= rd_q.life > cmd_q.elapsed;
		if (q_pop) cmd_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ri_q <= '0;
			wi_q <= '0;
			bit_q <= '0;
			fac_q <= 17'd32768;
			res_valid <= 1'b0;
			draw_x <= '0;
			draw_y <= '0;
			draw_color <= '0;
			frame <= 1'b0;
			status <= ppu_pkg::StOk;
			live_count <= '0;
			last <= 1'b0;
		end else begin
			res_valid <= (state_q == S_DONE) ||
				(state_q == S_RD && cmd_q.op == ppu_pkg::OP_LIST) ||
				(state_q == S_IDLE && q_valid && q_cmd.op == ppu_pkg::OP_CREATE);
			unique case (state_q)
				S_IDLE: begin
					ri_q <= '0;
					wi_q <= '0;
					bit_q <= 4'd0;
					fac_q <= 17'd32768;
					if (q_valid) begin
						unique case (q_cmd.op) inside
							ppu_pkg::OP_CREATE: begin
								draw_x <= '0;
								draw_y <= '0;
								draw_color <= '0;
								frame <= 1'b0;
								last <= 1'b1;
								if (count_q < CW'(POOL_DEPTH)) begin
									count_q <= count_q + 1'b1;
									status <= ppu_pkg::StOk;
									live_count <= 7'(count_q + 1'b1);
								end else begin
									status <= ppu_pkg::StFull;
									live_count <= 7'(count_q);
								end
							end
							ppu_pkg::OP_TICK: state_q <= S_DECAY;
							ppu_pkg::OP_ACCEL, ppu_pkg::OP_MOVE, ppu_pkg::OP_LIST:
								state_q <= (count_q == '0) ? S_DONE : S_WAIT;
							ppu_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_DECAY: begin
					// one fraction bit per cycle, msb first
					fac_q <= (bit_q == 4'd11) ? (fac_nxt >> cmd_q.elapsed[15:12]) : fac_nxt;
					if (bit_q == 4'd11)
						state_q <= (count_q == '0) ? S_DONE : S_WAIT;
					bit_q <= bit_q + 1'b1;
				end
				S_WAIT: state_q <= S_RD;
				S_RD: begin
					// rd_q holds entry ri_q
					if (cmd_q.op == ppu_pkg::OP_LIST) begin
						draw_x <= ppu_pkg::sat24(26'($signed(rd_q.px)) - 26'sd256);
						draw_y <= ppu_pkg::sat24(26'($signed(rd_q.py)) - 26'sd256);
						draw_color <= rd_q.color;
						frame <= ppu_pkg::frame_of(rd_q.life);
						status <= ppu_pkg::StOk;
						live_count <= 7'(count_q);
						last <= (ri_q + 1'b1) == count_q;
						ri_q <= ri_q + 1'b1;
						state_q <= ((ri_q + 1'b1) == count_q) ? S_IDLE : S_WAIT;
					end else state_q <= S_MUL;
				end
				S_MUL: begin
					if (cmd_q.op == ppu_pkg::OP_TICK) state_q <= S_WR;
					else begin
						ri_q <= ri_q + 1'b1;
						state_q <= ((ri_q + 1'b1) == count_q) ? S_DONE : S_WAIT;
					end
				end
				S_WR: begin
					if (keep_s1) wi_q <= wi_q + 1'b1;
					ri_q <= ri_q + 1'b1;
					if ((ri_q + 1'b1) == count_q) begin
						count_q <= wi_q + CW'(keep_s1);
						state_q <= S_DONE;
					end else state_q <= S_WAIT;
				end
				S_DONE: begin
					draw_x <= '0;
					draw_y <= '0;
					draw_color <= '0;
					frame <= 1'b0;
					last <= 1'b1;
					live_count <= 7'(count_q);
					status <= (cmd_q.op == ppu_pkg::OP_LIST) ? ppu_pkg::StEmpty : ppu_pkg::StOk;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PPU_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(POOL_DEPTH))
	`PPU_ASSERT_IMP(a_wr_behind_rd, clk, arst_n, state_q != S_IDLE, wi_q <= ri_q)
	`PPU_ASSERT_NEXT(a_done_result, clk, arst_n, state_q == S_DONE, res_valid && last)
	`PPU_ASSERT_IMP(a_idle_no_pop_busy, clk, arst_n, q_pop, !back_busy)

endmodule

@@ hw/rtl/particle_pool_update.sv @@
// channel  | signals                                        | beat
// command  | start, busy, op, pos/vel xy, life, tint, ...   | start && !busy
// result   | res_valid, draw_x/y, draw_color, frame, ...    | res_valid
// tick first forms the decay factor from elapsed, msb first, then reads, multiplies
// and writes back each particle that still has life; accelerate and move read and
// rewrite each particle, and list reads each one out. one op is worked at a time.
// arst_n clears pool count and control; pool contents are undefined until written.
// results cannot be held off: each is valid for exactly one cycle.
module particle_pool_update #(
	parameter int unsigned POOL_DEPTH = ppu_pkg::PoolDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] vel_x,
	input  logic signed [23:0] vel_y,
	input  logic [15:0]        life,
	input  logic [31:0]        tint,
	input  logic [15:0]        elapsed,
	input  logic signed [23:0] delta_x,
	input  logic signed [23:0] delta_y,
	output logic               res_valid,
	output logic signed [23:0] draw_x,
	output logic signed [23:0] draw_y,
	output logic [31:0]        draw_color,
	output logic               frame,
	output logic [1:0]         status,
	output logic [6:0]         live_count,
	output logic               last
);

	ppu_pkg::cmd_t cmd_in, q_cmd;
	logic q_valid, q_pop, back_busy;

	always_comb begin
		cmd_in.op = op;
		// classified here: create carries position, the other ops carry delta
		cmd_in.a_x = (op == ppu_pkg::OP_CREATE) ? pos_x : delta_x;
		cmd_in.a_y = (op == ppu_pkg::OP_CREATE) ? pos_y : delta_y;
		cmd_in.v_x = vel_x;
		cmd_in.v_y = vel_y;
		cmd_in.life = life;
		cmd_in.tint = tint;
		cmd_in.elapsed = elapsed;
	end

	ppu_front u_front (
		.clk, .arst_n, .start, .busy, .cmd_in,
		.q_valid, .q_cmd, .q_pop, .back_busy
	);

	ppu_back #(.POOL_DEPTH(POOL_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_cmd, .q_pop, .back_busy,
		.res_valid, .draw_x, .draw_y, .draw_color, .frame, .status, .live_count, .last
	);

endmodule

@@ test/ppu_checker.sv @@
module ppu_checker #(
	parameter int unsigned POOL_DEPTH = ppu_pkg::PoolDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         op,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] vel_x,
	input  logic signed [23:0] vel_y,
	input  logic [15:0]        life,
	input  logic [31:0]        tint,
	input  logic [15:0]        elapsed,
	input  logic signed [23:0] delta_x,
	input  logic signed [23:0] delta_y,
	input  logic               res_valid,
	input  logic signed [23:0] draw_x,
	input  logic signed [23:0] draw_y,
	input  logic [31:0]        draw_color,
	input  logic               frame,
	input  logic [1:0]         status,
	input  logic [6:0]         live_count,
	input  logic               last,
	output int                 fail_count,
	output int                 pending,
	output int                 result_total
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [23:0] dx;
		logic [23:0] dy;
		logic [31:0] col;
		logic        fr;
		logic [1:0]  st;
		logic [6:0]  cnt;
		logic        lst;
	} draw_beat_t;

	draw_beat_t draw_q[$];

	longint px[POOL_DEPTH], py[POOL_DEPTH], vx[POOL_DEPTH], vy[POOL_DEPTH];
	int unsigned lf[POOL_DEPTH];
	logic [31:0] cl[POOL_DEPTH];
	int unsigned n_live;

	function automatic longint clamp24(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// divide by 2^s, rounding half toward plus infinity
	function automatic longint round_shift(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic life_frame(int unsigned l);
		if (l >= 2458) return 1'b0;
		if (l >= 1229) return 1'b1;
		if (l >= 615) return 1'b0;
		return 1'b1;
	endfunction

	function automatic longint decay_step(int k);
		case (k)
			0: return 23170; 1: return 27554; 2: return 30048; 3: return 31379;
			4: return 32066; 5: return 32415; 6: return 32591; 7: return 32679;
			8: return 32724; 9: return 32746; 10: return 32757; default: return 32762;
		endcase
	endfunction

	task automatic push_status(logic [1:0] st);
		draw_beat_t b;
		b = '0;
		b.st = st;
		b.cnt = n_live[6:0];
		b.lst = 1'b1;
		draw_q = {draw_q, b};
	endtask

	task automatic apply_command();
		longint f, nvx, nvy;
		int unsigned w;
		draw_beat_t b;
		case (op)
			ppu_pkg::OP_CREATE: begin
				if (n_live >= POOL_DEPTH) push_status(ppu_pkg::StFull);
				else begin
					px[n_live] = pos_x; py[n_live] = pos_y;
					vx[n_live] = vel_x; vy[n_live] = vel_y;
					lf[n_live] = life; cl[n_live] = tint;
					n_live++;
					push_status(ppu_pkg::StOk);
				end
			end
			ppu_pkg::OP_TICK: begin
				f = 32768;
				for (int k = 11; k >= 0; k--)
					if (elapsed[k]) f = round_shift(f * decay_step(11 - k), 15);
				f = f >> elapsed[15:12];
				w = 0;
				for (int i = 0; i < n_live; i++) begin
					if (lf[i] > elapsed) begin
						nvx = clamp24(round_shift(vx[i] * f, 15));
						nvy = clamp24(round_shift(vy[i] * f, 15));
						px[w] = clamp24(px[i] + round_shift(vx[i] * longint'(elapsed), 12));
						py[w] = clamp24(py[i] + round_shift(vy[i] * longint'(elapsed), 12));
						vx[w] = nvx; vy[w] = nvy;
						lf[w] = lf[i] - elapsed; cl[w] = cl[i];
						w++;
					end
				end
				n_live = w;
				push_status(ppu_pkg::StOk);
			end
			ppu_pkg::OP_ACCEL: begin
				for (int i = 0; i < n_live; i++) begin
					vx[i] = clamp24(vx[i] + delta_x);
					vy[i] = clamp24(vy[i] + delta_y);
				end
				push_status(ppu_pkg::StOk);
			end
			ppu_pkg::OP_MOVE: begin
				for (int i = 0; i < n_live; i++) begin
					px[i] = clamp24(px[i] + delta_x);
					py[i] = clamp24(py[i] + delta_y);
				end
				push_status(ppu_pkg::StOk);
			end
			ppu_pkg::OP_CLEAR: begin
				n_live = 0;
				push_status(ppu_pkg::StOk);
			end
			ppu_pkg::OP_LIST: begin
				if (n_live == 0) push_status(ppu_pkg::StEmpty);
				else for (int i = 0; i < n_live; i++) begin
					b.dx = clamp24(px[i] - 256);
					b.dy = clamp24(py[i] - 256);
					b.col = cl[i];
					b.fr = life_frame(lf[i]);
					b.st = ppu_pkg::StOk;
					b.cnt = n_live[6:0];
					b.lst = (i + 1 == n_live);
					draw_q = {draw_q, b};
				end
			end
			default: push_status(ppu_pkg::StOk);
		endcase
	endtask

	initial begin
		fail_count = 0;
		result_total = 0;
		n_live = 0;
	end

	assign pending = draw_q.size();

	always @(posedge clk) begin
		draw_beat_t e;
		if (arst_n) begin
			// results first: a command beat can never cause a result in the same cycle
			if (res_valid) begin
				result_total <= result_total + 1;
				if (draw_q.size() == 0) begin
					$display("%0t: unexpected result beat, status %0d", $realtime, status);
					fail_count <= fail_count + 1;
				end else begin
					e = draw_q.pop_front();
					if (e != {draw_x, draw_y, draw_color, frame, status, live_count, last}) begin
						$display("%0t: mismatch exp x=%0d y=%0d col=%h fr=%0d st=%0d n=%0d l=%0d",
							$realtime, $signed(e.dx), $signed(e.dy), e.col, e.fr, e.st,
							e.cnt, e.lst);
						$display("%0t:          act x=%0d y=%0d col=%h fr=%0d st=%0d n=%0d l=%0d",
							$realtime, draw_x, draw_y, draw_color, frame, status,
							live_count, last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) apply_command();
		end
	end
endmodule

@@ test/tb_particle_pool_update.sv @@
module tb_particle_pool_update;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = ppu_pkg::PoolDepthDefault;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] op = '0;
	logic signed [23:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
	logic [15:0] life = '0, elapsed = '0;
	logic [31:0] tint = '0;
	logic signed [23:0] delta_x = '0, delta_y = '0;
	logic res_valid, frame, last;
	logic signed [23:0] draw_x, draw_y;
	logic [31:0] draw_color;
	logic [1:0] status;
	logic [6:0] live_count;
	int fail_count, pending, result_total;
	int idle_pct;
	int cmd_total;
	longint cycles = 0;

	always #6 clk = ~clk;

	particle_pool_update #(.POOL_DEPTH(DEPTH)) u_top (.*);
	ppu_checker #(.POOL_DEPTH(DEPTH)) u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_particle_pool_update: errors");
			$finish;
		end
	end

	function automatic logic [23:0] wild24();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 2047) - 1024);
			default: return 24'($urandom());
		endcase
	endfunction

	// one command beat; holds start until busy is seen low at an edge
	task automatic issue(logic [2:0] o, logic [23:0] ax, logic [23:0] ay,
			logic [23:0] bx, logic [23:0] by, logic [15:0] l, logic [31:0] c,
			logic [15:0] el);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		op <= o;
		pos_x <= ax; pos_y <= ay; vel_x <= bx; vel_y <= by;
		delta_x <= ax; delta_y <= ay;
		life <= l; tint <= c; elapsed <= el;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		cmd_total++;
	endtask

	task automatic random_cmd();
		logic [2:0] o;
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) o = ppu_pkg::OP_CREATE;
		else if (r < 62) o = ppu_pkg::OP_TICK;
		else if (r < 70) o = ppu_pkg::OP_ACCEL;
		else if (r < 78) o = ppu_pkg::OP_MOVE;
		else if (r < 81) o = ppu_pkg::OP_CLEAR;
		else if (r < 97) o = ppu_pkg::OP_LIST;
		else o = 3'($urandom_range(6, 7));
		issue(o, wild24(), wild24(), wild24(), wild24(),
			($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6000)),
			$urandom(),
			($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1500)));
	endtask

	initial begin
		idle_pct = 0;
		cmd_total = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, extremes, zero life, overflow, full pool, unknown ops
		issue(ppu_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, 0);
		issue(ppu_pkg::OP_CREATE, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
			16'hFFFF, 32'hFFFFFFFF, 0);
		issue(ppu_pkg::OP_CREATE, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
			16'd0, 0, 0);
		issue(ppu_pkg::OP_CREATE, 24'h000100, 24'hFFFF00, 24'h000800, 24'hFFF800,
			16'd2458, 32'h12345678, 0);
		issue(ppu_pkg::OP_CREATE, 0, 0, 24'h7FFFFF, 24'h800000, 16'd1229,
			32'hA5A5A5A5, 0);
		issue(ppu_pkg::OP_CREATE, 0, 0, 0, 0, 16'd615, 32'h5A5A5A5A, 0);
		issue(ppu_pkg::OP_CREATE, 0, 0, 0, 0, 16'd614, 32'h0, 0);
		issue(ppu_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, 0);
		issue(ppu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 16'd1);
		issue(ppu_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, 0);
		issue(ppu_pkg::OP_ACCEL, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0);
		issue(ppu_pkg::OP_MOVE, 24'h800000, 24'h7FFFFF, 0, 0, 0, 0, 0);
		issue(ppu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 16'h0FFF);
		issue(ppu_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, 0);
		issue(3'd6, 0, 0, 0, 0, 0, 0, 0);
		issue(3'd7, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < DEPTH + 2; i++)
			issue(ppu_pkg::OP_CREATE, 24'($urandom()), 24'($urandom()), 24'($urandom()),
				24'($urandom()), 16'hFFFF, $urandom(), 0);
		issue(ppu_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, 0);
		issue(ppu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 16'hF000);
		issue(ppu_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, 0);
		issue(ppu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF);
		issue(ppu_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		issue(ppu_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, 0);
		start <= 1'b0;

		// hold off until everything has drained
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 31 : (ph == 1) ? 58 : 0;
			for (int i = 0; i < 100; i++) random_cmd();
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d commands, %0d result beats: create up to full pool, tick with decay,",
			cmd_total, result_total);
		$display("saturating accelerate and move, clear, list, unknown ops");
		if (fail_count == 0 && pending == 0) begin
			$display("tb_particle_pool_update: clean");
		end else begin
			$display("tb_particle_pool_update: errors");
		end
		$finish;
	end
endmodule

@@ particle_pool_update.f @@
+incdir+hw/rtl
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_front.sv
hw/rtl/ppu_back.sv
hw/rtl/particle_pool_update.sv
test/ppu_checker.sv
test/tb_particle_pool_update.sv
